@@ hw/rtl/ppp_pkg.sv @@
package ppp_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned HalfW  = 31;
  localparam int unsigned ProdW  = 63;  // signed 32 x unsigned 31
  localparam int unsigned QuotW  = 63;  // magnitude of the quotient
  localparam int unsigned AddrW  = 3;

  localparam logic [AddrW-1:0] AddrHalfWidth  = 3'd0;
  localparam logic [AddrW-1:0] AddrHalfHeight = 3'd4;

  localparam logic [QuotW-1:0] LimitMag = 63'h7fffffff;

  typedef enum logic [1:0] {
    StSkipped   = 2'd0,
    StProjected = 2'd1,
    StOverflow  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic                     already_projected;
    logic                     behind_viewer;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] screen_x;
    logic signed [CoordW-1:0] screen_y;
    status_e                  status;
  } screen_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic                     skip;
    logic                     zero_z;
    logic                     neg_x;   // sign of the x product
    logic                     neg_y;
    logic                     neg_z;
    logic [ProdW-1:0]         mag_px;  // |x * half_width|
    logic [ProdW-1:0]         mag_py;
    logic [CoordW-1:0]        mag_z;   // |z|, up to 2^31
    logic [HalfW-1:0]         half_w;
    logic [HalfW-1:0]         half_h;
  } job_t;

endpackage

@@ hw/rtl/ppp_if.sv @@
interface ppp_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/ppp_front.sv @@
module ppp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [ppp_pkg::HalfW-1:0] half_w_i,
  input  logic [ppp_pkg::HalfW-1:0] half_h_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ppp_pkg::point_t in_data_i,
  output logic          job_valid_o,
  input  logic          job_ready_i,
  output ppp_pkg::job_t job_o
);
  import ppp_pkg::*;

  logic          valid_q;
  job_t          job_q, job_d;
  logic [CoordW-1:0] ax, ay;
  logic [ProdW-1:0]  px, py;

  assign in_ready_o = !valid_q || job_ready_i;

  always_comb begin
    ax = in_data_i.point_x[CoordW-1] ? CoordW'(-in_data_i.point_x) : in_data_i.point_x;
    ay = in_data_i.point_y[CoordW-1] ? CoordW'(-in_data_i.point_y) : in_data_i.point_y;
    px = ProdW'(ax) * ProdW'(half_w_i);
    py = ProdW'(ay) * ProdW'(half_h_i);
    job_d.skip   = in_data_i.already_projected | in_data_i.behind_viewer;
    job_d.zero_z = (in_data_i.point_z == '0);
    job_d.neg_x  = in_data_i.point_x[CoordW-1];
    job_d.neg_y  = in_data_i.point_y[CoordW-1];
    job_d.neg_z  = in_data_i.point_z[CoordW-1];
    job_d.mag_px = px;
    job_d.mag_py = py;
    job_d.mag_z  = in_data_i.point_z[CoordW-1] ? CoordW'(-in_data_i.point_z)
                                                 : in_data_i.point_z;
    job_d.half_w = half_w_i;
    job_d.half_h = half_h_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = valid_q;
  assign job_o       = job_q;
endmodule

@@ hw/rtl/ppp_fifo.sv @@
module ppp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  ppp_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output ppp_pkg::job_t rd_data_o
);
  import ppp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t              mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     count_q;
  logic              push, pop;

  assign wr_ready_o = (count_q != (PtrW+1)'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end
endmodule

@@ hw/rtl/ppp_back.sv @@
// Pipelined restoring divider: one quotient bit per stage for both axes.
module ppp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  ppp_pkg::job_t job_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ppp_pkg::screen_t out_data_o
);
  import ppp_pkg::*;

  localparam int unsigned Stages = ProdW;
  localparam int unsigned RemW   = CoordW + 1;

  typedef struct packed {
    logic              skip;
    logic              zero_z;
    logic              neg_qx;
    logic              neg_qy;
    logic [ProdW-1:0]  nx;      // numerator bits still to shift in, then quotient
    logic [ProdW-1:0]  ny;
    logic [RemW-1:0]   rx;
    logic [RemW-1:0]   ry;
    logic [CoordW-1:0] dz;
    logic [HalfW-1:0]  half_w;
    logic [HalfW-1:0]  half_h;
  } div_t;

  logic  advance;
  logic  vld_q [Stages+1];
  div_t  st_q  [Stages+1];
  div_t  st_d  [Stages+1];
  logic  out_valid_q;
  screen_t out_q, out_d;
  logic [QuotW-1:0] qx, qy;
  logic [CoordW-1:0] tx, ty;

  // Whole pipe moves together; stall when the output is full and not taken.
  assign advance     = !out_valid_q || out_ready_i;
  assign job_ready_o = advance;

  always_comb begin
    st_d[0].skip   = job_i.skip;
    st_d[0].zero_z = job_i.zero_z;
    st_d[0].neg_qx = job_i.neg_x ^ job_i.neg_z;
    st_d[0].neg_qy = job_i.neg_y ^ job_i.neg_z;
    st_d[0].nx     = job_i.mag_px;
    st_d[0].ny     = job_i.mag_py;
    st_d[0].rx     = '0;
    st_d[0].ry     = '0;
    st_d[0].dz     = job_i.mag_z;
    st_d[0].half_w = job_i.half_w;
    st_d[0].half_h = job_i.half_h;
  end

  for (genvar s = 0; s < Stages; s++) begin : g_div
    logic [RemW-1:0] shx, shy;
    always_comb begin
      st_d[s+1] = st_q[s];
      shx = {st_q[s].rx[RemW-2:0], st_q[s].nx[ProdW-1]};
      shy = {st_q[s].ry[RemW-2:0], st_q[s].ny[ProdW-1]};
      if (shx >= RemW'(st_q[s].dz)) begin
        st_d[s+1].rx = shx - RemW'(st_q[s].dz);
        st_d[s+1].nx = {st_q[s].nx[ProdW-2:0], 1'b1};
      end else begin
        st_d[s+1].rx = shx;
        st_d[s+1].nx = {st_q[s].nx[ProdW-2:0], 1'b0};
      end
      if (shy >= RemW'(st_q[s].dz)) begin
        st_d[s+1].ry = shy - RemW'(st_q[s].dz);
        st_d[s+1].ny = {st_q[s].ny[ProdW-2:0], 1'b1};
      end else begin
        st_d[s+1].ry = shy;
        st_d[s+1].ny = {st_q[s].ny[ProdW-2:0], 1'b0};
      end
    end
  end

  for (genvar s = 0; s <= Stages; s++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (advance) begin
        vld_q[s] <= (s == 0) ? job_valid_i : vld_q[(s == 0) ? 0 : s-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (advance) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  always_comb begin
    qx = st_q[Stages].nx;
    qy = st_q[Stages].ny;
    tx = st_q[Stages].neg_qx ? CoordW'(-qx) : CoordW'(qx);
    ty = st_q[Stages].neg_qy ? CoordW'(-qy) : CoordW'(qy);
    out_d.screen_x = '0;
    out_d.screen_y = '0;
    priority if (st_q[Stages].skip) begin
      out_d.status = StSkipped;
    end else if (st_q[Stages].zero_z || qx > LimitMag || qy > LimitMag) begin
      out_d.status = StOverflow;
    end else begin
      out_d.status   = StProjected;
      out_d.screen_x = CoordW'(st_q[Stages].half_w) + tx;
      out_d.screen_y = CoordW'(st_q[Stages].half_h) - ty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= vld_q[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

@@ hw/rtl/perspective_point_projector.sv @@
// Perspective point projector, 16.16 fixed point. Accepts one point word per
// cycle and returns one screen word per point, in order. The datapath runs
// thus: one front stage forms the two exact 63-bit magnitude products and
// classifies the point, a two-word queue decouples it from the back, and the
// back runs a 63-stage restoring divider (one quotient bit per stage, x and y
// side by side) followed by a result register. Throughput is one point per
// cycle while the output is taken. Skipped points give status 0 with zero
// coordinates; zero depth or a quotient beyond +/-0x7fffffff gives status 2.
// half_width sits at APB address 0 and half_height at 4; write them only while
// the block is idle. Values are sampled as each point enters.
module perspective_point_projector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ppp_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ppp_if.sink         in_if,
  ppp_if.source       out_if
);
  import ppp_pkg::*;

  logic [HalfW-1:0] half_w_q, half_h_q;
  logic  job_valid, job_ready, q_valid, q_ready;
  job_t  job, q_job;

  assign pready = 1'b1;

  // Register file: write on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_w_q <= HalfW'(20971520);
      half_h_q <= HalfW'(15728640);
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrHalfWidth) begin
        half_w_q <= pwdata[HalfW-1:0];
      end else if (paddr == AddrHalfHeight) begin
        half_h_q <= pwdata[HalfW-1:0];
      end
    end
  end

  always_comb begin
    unique case (paddr)
      AddrHalfWidth:  prdata = {1'b0, half_w_q};
      AddrHalfHeight: prdata = {1'b0, half_h_q};
      default:        prdata = '0;
    endcase
  end

  ppp_front u_front (
    .clk_i, .rst_ni,
    .half_w_i    (half_w_q),
    .half_h_i    (half_h_q),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_data_i   (in_if.data),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  ppp_fifo #(.Depth(2)) u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i (job_valid),
    .wr_ready_o (job_ready),
    .wr_data_i  (job),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_job)
  );

  ppp_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.data)
  );
endmodule

@@ hw/rtl/ppp_checker.sv @@
module ppp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic [31:0] out_sx,
  input logic [31:0] out_sy
);
  import ppp_pkg::*;

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_status == StSkipped || out_status == StProjected ||
                   out_status == StOverflow))
    else $error("bad status code");

  a_zero_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status != StProjected |-> out_sx == '0 && out_sy == '0)
    else $error("coordinates not zero on non-projected word");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("stalled word changed");
endmodule

bind perspective_point_projector ppp_checker u_ppp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_status (out_if.data.status),
  .out_sx     (out_if.data.screen_x),
  .out_sy     (out_if.data.screen_y)
);
